FILE: rtl/afi_pkg.sv
// ----------------------------------------------------------------------------
// Affine inverse package
// Payload types, stage bundles and fixed widths shared by the inverse pipeline.
// ----------------------------------------------------------------------------
package afi_pkg;

    // Widths of the exact intermediate values.
    localparam int COF_W   = 65;   // signed 2x2 minor
    localparam int DET_W   = 99;   // signed determinant
    localparam int CMP_W   = 131;  // dividend and shifted divisor
    localparam int NUM_ENT = 9;    // matrix entries
    localparam int NSTEP   = 33;   // divider stages: range check plus 32 quotient bits

    localparam logic [1:0] COL_X0   = 2'd0;
    localparam logic [1:0] COL_X1   = 2'd1;
    localparam logic [1:0] COL_X2   = 2'd2;
    localparam logic [1:0] COL_XLAT = 2'd3;

    typedef struct packed {
        logic signed [31:0] col1_x;
        logic signed [31:0] col1_y;
        logic signed [31:0] col1_z;
        logic signed [31:0] col2_x;
        logic signed [31:0] col2_y;
        logic signed [31:0] col2_z;
        logic signed [31:0] col3_x;
        logic signed [31:0] col3_y;
        logic signed [31:0] col3_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } afi_in_t;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               singular;
        logic               saturated;
        logic               last;
    } afi_out_t;

    // Values that ride alongside the dividers.
    typedef struct packed {
        logic [NUM_ENT-1:0] sgn;
        logic               singular;
        logic [2:0][31:0]   off;
    } afi_side_t;

    // Division jobs for all nine entries of one transform.
    typedef struct packed {
        logic [NUM_ENT-1:0][CMP_W-1:0] num;
        logic [CMP_W-1:0]              den;
        afi_side_t                     side;
    } afi_job_t;

    typedef struct packed {
        logic [NUM_ENT-1:0][31:0] q;
        logic [NUM_ENT-1:0]       ovf;
        afi_side_t                side;
    } afi_quo_t;

    // Finished inverse: entry 3*row+col, translation by row.
    typedef struct packed {
        logic [NUM_ENT-1:0][31:0] inv;
        logic [2:0][31:0]         xl;
        logic [3:0]               sat;
        logic                     singular;
    } afi_res_t;

endpackage

FILE: rtl/afi_det.sv
// ----------------------------------------------------------------------------
// Affine inverse front end
// Minors, determinant and the rounded division operands, in six stages.
// ----------------------------------------------------------------------------
module afi_det #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  afi_pkg::afi_in_t   in_data,
    output logic               out_valid,
    output afi_pkg::afi_job_t  job
);

    localparam int NE = afi_pkg::NUM_ENT;

    logic signed [31:0] m [3][3];
    logic signed [31:0] off_in [3];

    logic [5:0] valid_reg;

    logic signed [63:0] pa_reg [NE];
    logic signed [63:0] pb_reg [NE];
    logic signed [afi_pkg::COF_W-1:0] cof_reg [4][NE];
    logic signed [31:0] m0_reg [2][3];
    logic signed [31:0] off_reg [5][3];
    logic signed [afi_pkg::COF_W-1:0] plo_reg [3];
    logic signed [afi_pkg::COF_W-1:0] phi_reg [3];
    logic signed [afi_pkg::DET_W-1:0] term_reg [3];
    logic signed [afi_pkg::DET_W-1:0] det_reg;
    afi_pkg::afi_job_t job_reg;
    afi_pkg::afi_job_t job_next;

    // Row r, column c of the matrix.
    assign m[0][0] = in_data.col1_x;
    assign m[1][0] = in_data.col1_y;
    assign m[2][0] = in_data.col1_z;
    assign m[0][1] = in_data.col2_x;
    assign m[1][1] = in_data.col2_y;
    assign m[2][1] = in_data.col2_z;
    assign m[0][2] = in_data.col3_x;
    assign m[1][2] = in_data.col3_y;
    assign m[2][2] = in_data.col3_z;
    assign off_in[0] = in_data.offset_x;
    assign off_in[1] = in_data.offset_y;
    assign off_in[2] = in_data.offset_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int E  = 3 * r + c;
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pa_reg[E]     <= m[C1][R1] * m[C2][R2];
                    pb_reg[E]     <= m[C1][R2] * m[C2][R1];
                    cof_reg[0][E] <= afi_pkg::COF_W'(pa_reg[E]) - afi_pkg::COF_W'(pb_reg[E]);
                    cof_reg[1][E] <= cof_reg[0][E];
                    cof_reg[2][E] <= cof_reg[1][E];
                    cof_reg[3][E] <= cof_reg[2][E];
                end
            end
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_det
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m0_reg[0][c] <= m[c][0];
                m0_reg[1][c] <= m0_reg[0][c];
                off_reg[0][c] <= off_in[c];
                off_reg[1][c] <= off_reg[0][c];
                off_reg[2][c] <= off_reg[1][c];
                off_reg[3][c] <= off_reg[2][c];
                off_reg[4][c] <= off_reg[3][c];
                // The first-row minor is split into an unsigned low word and a
                // signed high part so each multiplier stays near 32 by 32.
                plo_reg[c] <= $signed({1'b0, cof_reg[0][c][31:0]}) * m0_reg[1][c];
                phi_reg[c] <= $signed(cof_reg[0][c][afi_pkg::COF_W-1:32]) * m0_reg[1][c];
                term_reg[c] <= (afi_pkg::DET_W'(phi_reg[c]) <<< 32)
                             + afi_pkg::DET_W'(plo_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            job_reg <= job_next;
        end
    end

    always_comb
    begin
        logic                      det_neg;
        logic [afi_pkg::DET_W-1:0] det_mag;
        logic                      cneg;
        logic [afi_pkg::COF_W-1:0] cabs;
        det_neg = det_reg[afi_pkg::DET_W-1];
        det_mag = det_neg ? afi_pkg::DET_W'(-det_reg) : afi_pkg::DET_W'(det_reg);
        job_next = '0;
        for (int e = 0; e < NE; e++)
        begin
            cneg = cof_reg[3][e][afi_pkg::COF_W-1];
            cabs = cneg ? afi_pkg::COF_W'(-cof_reg[3][e]) : afi_pkg::COF_W'(cof_reg[3][e]);
            job_next.num[e] = (afi_pkg::CMP_W'(cabs[63:0]) << (2 * FRAC_BITS + 1))
                            + afi_pkg::CMP_W'(det_mag);
            job_next.side.sgn[e] = cneg ^ det_neg;
        end
        job_next.den = afi_pkg::CMP_W'(det_mag) << 1;
        job_next.side.singular = (det_reg == '0);
        for (int c = 0; c < 3; c++)
        begin
            job_next.side.off[c] = off_reg[4][c];
        end
    end

    assign out_valid = valid_reg[5];
    assign job       = job_reg;

endmodule

FILE: rtl/afi_div.sv
// ----------------------------------------------------------------------------
// Affine inverse divider bank
// Nine restoring dividers, one quotient bit per stage, after a range check.
// ----------------------------------------------------------------------------
module afi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  afi_pkg::afi_job_t  job,
    output logic               out_valid,
    output afi_pkg::afi_quo_t  quo
);

    localparam int NE = afi_pkg::NUM_ENT;
    localparam int NS = afi_pkg::NSTEP;
    localparam int W  = afi_pkg::CMP_W;

    logic [NS-1:0]  valid_reg;
    logic [W-1:0]   rem_reg [NS][NE];
    logic [31:0]    q_reg   [NS][NE];
    logic           ovf_reg [NS][NE];
    logic [W-1:0]   den_reg [NS];
    afi_pkg::afi_side_t side_reg [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= job.den;
            side_reg[0] <= job.side;
            for (int k = 1; k < NS; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar e = 0; e < NE; e++)
    begin : g_lane
        // A quotient of 2^32 or more is clipped anyway, so only 32 bits are formed.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[0][e] <= job.num[e];
                q_reg[0][e]   <= '0;
                ovf_reg[0][e] <= (job.num[e] >= (job.den << 32));
            end
        end
        for (genvar k = 1; k < NS; k++)
        begin : g_step
            localparam int BIT = NS - 1 - k;
            logic [W-1:0] shd;
            logic         take;
            assign shd  = den_reg[k-1] << BIT;
            assign take = (rem_reg[k-1][e] >= shd);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k][e] <= take ? rem_reg[k-1][e] - shd : rem_reg[k-1][e];
                    q_reg[k][e]   <= q_reg[k-1][e] | (take ? (32'd1 << BIT) : 32'd0);
                    ovf_reg[k][e] <= ovf_reg[k-1][e];
                end
            end
        end
        assign quo.q[e]   = q_reg[NS-1][e];
        assign quo.ovf[e] = ovf_reg[NS-1][e];
    end

    assign quo.side  = side_reg[NS-1];
    assign out_valid = valid_reg[NS-1];

endmodule

FILE: rtl/afi_xlat.sv
// ----------------------------------------------------------------------------
// Affine inverse back end
// Clips the inverse entries and forms the negated, rounded new translation.
// ----------------------------------------------------------------------------
module afi_xlat #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  afi_pkg::afi_quo_t  quo,
    output logic               out_valid,
    output afi_pkg::afi_res_t  res
);

    localparam int NE = afi_pkg::NUM_ENT;

    logic [3:0] valid_reg;

    logic signed [31:0] inv_reg [3][NE];
    logic [2:0]         sat_reg [3];
    logic               sing_reg [3];
    logic signed [31:0] off_reg [3];
    logic signed [63:0] prod_reg [3][3];
    logic signed [65:0] sum_reg [3];
    afi_pkg::afi_res_t  res_reg;

    logic signed [31:0] inv_next [NE];
    logic [2:0]         sat_next;
    logic [31:0]        xl_next [3];
    logic               xsat_next;

    function automatic logic [32:0] clip_div(input logic neg, input logic [31:0] q,
                                             input logic ovf);
        logic sat;
        logic [31:0] v;
        sat = ovf || (neg ? (q > 32'h8000_0000) : (q > 32'h7FFF_FFFF));
        if (sat)
        begin
            v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            v = neg ? -q : q;
        end
        return {sat, v};
    endfunction

    function automatic afi_pkg::afi_res_t res_next();
        afi_pkg::afi_res_t rv;
        for (int e = 0; e < NE; e++)
        begin
            rv.inv[e] = inv_reg[2][e];
        end
        for (int r = 0; r < 3; r++)
        begin
            rv.xl[r] = xl_next[r];
        end
        rv.sat      = {xsat_next, sat_reg[2]};
        rv.singular = sing_reg[2];
        return rv;
    endfunction

    always_comb
    begin
        logic [32:0] cv;
        sat_next = '0;
        for (int e = 0; e < NE; e++)
        begin
            cv = clip_div(quo.side.sgn[e], quo.q[e], quo.ovf[e]);
            inv_next[e] = quo.side.singular ? 32'sd0 : $signed(cv[31:0]);
            sat_next[e % 3] = sat_next[e % 3] | (cv[32] & !quo.side.singular);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < NE; e++)
            begin
                inv_reg[0][e] <= inv_next[e];
                inv_reg[1][e] <= inv_reg[0][e];
                inv_reg[2][e] <= inv_reg[1][e];
            end
            sat_reg[0]  <= sat_next;
            sat_reg[1]  <= sat_reg[0];
            sat_reg[2]  <= sat_reg[1];
            sing_reg[0] <= quo.side.singular;
            sing_reg[1] <= sing_reg[0];
            sing_reg[2] <= sing_reg[1];
            for (int c = 0; c < 3; c++)
            begin
                off_reg[c] <= $signed(quo.side.off[c]);
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= inv_reg[0][3*r+c] * off_reg[c];
                end
                sum_reg[r] <= 66'(prod_reg[r][0]) + 66'(prod_reg[r][1]) + 66'(prod_reg[r][2]);
            end
            res_reg <= res_next();
        end
    end

    // The translation is negated, so a nonnegative sum gives a result that is negative or zero.
    always_comb
    begin
        logic        sneg;
        logic [65:0] sabs;
        logic [65:0] mag;
        logic        neg;
        logic        sat;
        xsat_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            sneg = sum_reg[r][65];
            sabs = sneg ? 66'(-sum_reg[r]) : 66'(sum_reg[r]);
            mag  = (sabs + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            neg  = !sneg;
            sat  = neg ? (mag > 66'h0_8000_0000) : (mag > 66'h0_7FFF_FFFF);
            if (sat)
            begin
                xl_next[r] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                xl_next[r] = neg ? -mag[31:0] : mag[31:0];
            end
            xsat_next = xsat_next | sat;
        end
    end

    assign out_valid = valid_reg[3];
    assign res       = res_reg;

endmodule

FILE: rtl/affine_transform_inverse.sv
// ----------------------------------------------------------------------------
// Affine transform inverse
// Inverts a Q16.16 3x4 affine transform by cofactors and emits four columns.
// ----------------------------------------------------------------------------
//  channel | signals                         | payload
//  --------+---------------------------------+--------------------------
//  input   | item_valid, item_stall, item    | matrix columns, offset
//  output  | res_valid, res_stall, res       | one column per transfer
//
// One transform enters per cycle while the output is free and leaves as four
// transfers; the output register takes the next transform only as its last
// column is handed over. Transforms pass afi_det, afi_div, afi_xlat and then
// that register. Reset clears only the valid bits and the column counter. A
// stall on a busy output freezes the whole pipeline and stalls the input in the same cycle.
// ----------------------------------------------------------------------------
module affine_transform_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  afi_pkg::afi_in_t  item,
    output logic              res_valid,
    input  logic              res_stall,
    output afi_pkg::afi_out_t res
);

    logic              adv;
    logic              det_valid;
    afi_pkg::afi_job_t job;
    logic              div_valid;
    afi_pkg::afi_quo_t quo;
    logic              xl_valid;
    afi_pkg::afi_res_t xl_res;

    logic              busy_reg;
    logic [1:0]        cnt_reg;
    afi_pkg::afi_res_t hold_reg;

    // The pipeline moves whenever the output register is empty or hands over
    // its last column in this cycle.
    assign adv        = !busy_reg || (!res_stall && (cnt_reg == afi_pkg::COL_XLAT));
    assign item_stall = !adv;

    afi_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item_valid),
        .in_data   (item),
        .out_valid (det_valid),
        .job       (job)
    );

    afi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (det_valid),
        .job       (job),
        .out_valid (div_valid),
        .quo       (quo)
    );

    afi_xlat #(.FRAC_BITS(FRAC_BITS)) u_xlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .quo       (quo),
        .out_valid (xl_valid),
        .res       (xl_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= afi_pkg::COL_X0;
        end
        else if (adv)
        begin
            busy_reg <= xl_valid;
            cnt_reg  <= afi_pkg::COL_X0;
        end
        else if (!res_stall)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hold_reg <= xl_res;
        end
    end

    always_comb
    begin
        res.column_index = cnt_reg;
        res.singular     = hold_reg.singular;
        res.last         = (cnt_reg == afi_pkg::COL_XLAT);
        case (cnt_reg)
            afi_pkg::COL_X0:
            begin
                res.out_x     = $signed(hold_reg.inv[0]);
                res.out_y     = $signed(hold_reg.inv[3]);
                res.out_z     = $signed(hold_reg.inv[6]);
                res.saturated = hold_reg.sat[0];
            end
            afi_pkg::COL_X1:
            begin
                res.out_x     = $signed(hold_reg.inv[1]);
                res.out_y     = $signed(hold_reg.inv[4]);
                res.out_z     = $signed(hold_reg.inv[7]);
                res.saturated = hold_reg.sat[1];
            end
            afi_pkg::COL_X2:
            begin
                res.out_x     = $signed(hold_reg.inv[2]);
                res.out_y     = $signed(hold_reg.inv[5]);
                res.out_z     = $signed(hold_reg.inv[8]);
                res.saturated = hold_reg.sat[2];
            end
            default:
            begin
                res.out_x     = $signed(hold_reg.xl[0]);
                res.out_y     = $signed(hold_reg.xl[1]);
                res.out_z     = $signed(hold_reg.xl[2]);
                res.saturated = hold_reg.sat[3];
            end
        endcase
    end

    assign res_valid = busy_reg;

`ifndef ASSERT_OFF
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !res_stall && (cnt_reg != afi_pkg::COL_XLAT))
        |=> (busy_reg && (cnt_reg == $past(cnt_reg) + 2'd1)))
        else $error("column index did not advance after a transfer");

    a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> (res.column_index == afi_pkg::COL_X0))
        else $error("a transform did not start at its first column");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !item_stall)
        else $error("input stalled while the output is empty");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.singular)
        |-> (res.out_x == 32'sd0 && res.out_y == 32'sd0 && res.out_z == 32'sd0
             && !res.saturated))
        else $error("singular transform gave a nonzero column");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine inverse testbench
// Feeds 3x4 transforms through the inverse pipeline under random bursts and
// output stalls, and checks every column against a cofactor-based predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC      = 16;
    localparam int NRANDOM   = 240;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN     = 100;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_stall;
    afi_pkg::afi_in_t  item = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    afi_pkg::afi_out_t res;

    afi_pkg::afi_in_t  pending_q[$];
    afi_pkg::afi_out_t column_q[$];
    int       errors = 0;
    int       n_sent = 0;
    int       n_cols = 0;
    int       n_singular = 0;
    int       n_sat = 0;
    int       idle_cycles = 0;
    bit       stim_done = 1'b0;
    bit       hold_off = 1'b0;

    affine_transform_inverse #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    always #1 clk = ~clk;

    // Clip a signed exact value to a 32-bit result with saturation.
    function automatic logic signed [31:0] clip_word(input logic signed [191:0] v,
                                                     inout logic sat);
        if (v > 192'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -192'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Magnitude quotient rounded half away from zero, sign applied after.
    function automatic logic signed [191:0] div_round(input logic signed [191:0] n,
                                                      input logic signed [191:0] d);
        logic [191:0] an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q  = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    task automatic predict_inverse(input afi_pkg::afi_in_t t);
        logic signed [191:0] m[3][3];
        logic signed [191:0] off[3];
        logic signed [191:0] cof[3][3];
        logic signed [191:0] det, s, mag;
        logic signed [31:0]  inv[3][3];
        logic signed [31:0]  xl[3];
        logic                sat[4];
        logic                sing;
        afi_pkg::afi_out_t   o;
        m[0][0] = t.col1_x; m[1][0] = t.col1_y; m[2][0] = t.col1_z;
        m[0][1] = t.col2_x; m[1][1] = t.col2_y; m[2][1] = t.col2_z;
        m[0][2] = t.col3_x; m[1][2] = t.col3_y; m[2][2] = t.col3_z;
        off[0] = t.offset_x; off[1] = t.offset_y; off[2] = t.offset_z;
        for (int k = 0; k < 4; k++) sat[k] = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                cof[r][c] = m[(c+1)%3][(r+1)%3] * m[(c+2)%3][(r+2)%3]
                          - m[(c+1)%3][(r+2)%3] * m[(c+2)%3][(r+1)%3];
                inv[r][c] = '0;
            end
        det = cof[0][0] * m[0][0] + cof[0][1] * m[1][0] + cof[0][2] * m[2][0];
        sing = (det == 0);
        for (int r = 0; r < 3; r++) xl[r] = '0;
        if (!sing)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    inv[r][c] = clip_word(div_round(cof[r][c] <<< (2 * FRAC), det),
                                          sat[c]);
            for (int r = 0; r < 3; r++)
            begin
                s = 0;
                for (int c = 0; c < 3; c++)
                    s += 192'(inv[r][c]) * off[c];
                mag = ((s < 0 ? -s : s) + (192'sd1 <<< (FRAC - 1))) >>> FRAC;
                xl[r] = clip_word(s < 0 ? mag : -mag, sat[3]);
            end
        end
        if (sing) n_singular++;
        for (int k = 0; k < 4; k++)
        begin
            o.column_index = (k == 0) ? afi_pkg::COL_X0 : (k == 1) ? afi_pkg::COL_X1 :
                             (k == 2) ? afi_pkg::COL_X2 : afi_pkg::COL_XLAT;
            o.out_x = (k == 3) ? xl[0] : inv[0][k];
            o.out_y = (k == 3) ? xl[1] : inv[1][k];
            o.out_z = (k == 3) ? xl[2] : inv[2][k];
            o.singular  = sing;
            o.saturated = sat[k];
            o.last      = (k == 3);
            if (sat[k]) n_sat++;
            column_q.push_back(o);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8'hFF) - 128) <<< FRAC);
            2: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000);
        endcase
    endfunction

    function automatic afi_pkg::afi_in_t scaled_identity(input logic [31:0] d);
        afi_pkg::afi_in_t t;
        t = '0;
        t.col1_x = d; t.col2_y = d; t.col3_z = d;
        return t;
    endfunction

    // Directed and random transforms.
    initial
    begin
        afi_pkg::afi_in_t t;
        t = '0; pending_q.push_back(t);                          // all zero, singular
        t = scaled_identity(32'h00010000); t.offset_x = 32'h00030000;
        t.offset_y = 32'hFFFE0000; t.offset_z = 32'h7FFFFFFF; pending_q.push_back(t);
        pending_q.push_back(scaled_identity(32'h00000001));       // huge inverse, clip
        pending_q.push_back(scaled_identity(32'h7FFFFFFF));
        pending_q.push_back(scaled_identity(32'h80000000));
        t = scaled_identity(32'hFFFF0000); t.offset_x = 32'h80000000;
        t.offset_y = 32'h80000000; t.offset_z = 32'h80000000; pending_q.push_back(t);
        t = scaled_identity(32'h00000001); t.offset_x = 32'h7FFFFFFF;
        pending_q.push_back(t);                                    // translation clips
        t = '1; pending_q.push_back(t);                            // rank one, singular
        t = '0; t.col1_x = 32'h00010000; t.col2_x = 32'h00010000; t.col3_z = 32'h1;
        pending_q.push_back(t);                                    // repeated column
        t = '0; t.col1_y = 32'h00020000; t.col2_x = 32'h00020000; t.col3_z = 32'hFFFF0000;
        pending_q.push_back(t);                                    // permutation
        t = scaled_identity(32'h00030000); pending_q.push_back(t); // rounding of 1/3
        for (int i = 0; i < 6; i++)
        begin
            t = {12{32'h80000000}};
            t.col1_x = 32'h7FFFFFFF; t.col2_y = 32'h7FFFFFFF;
            t.col3_z = i[0] ? 32'h7FFFFFFF : 32'h00000001;
            pending_q.push_back(t);
        end
        for (int i = 0; i < NRANDOM; i++)
        begin
            t = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word()};
            if ($urandom_range(0, 19) == 0) t.col3_x = t.col1_x;
            if ($urandom_range(0, 19) == 0)
            begin
                t.col2_x = t.col1_x; t.col2_y = t.col1_y; t.col2_z = t.col1_z;
            end
            pending_q.push_back(t);
        end
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
    end

    // Stall seen at the last rising edge.
    logic item_stall_q = 1'b0;

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || !item_stall_q)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    item <= pending_q.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // Sampled handshake at the rising edge.
    always @(posedge clk)
    begin
        item_stall_q <= item_stall;
        if (rst_n && item_valid && !item_stall)
        begin
            predict_inverse(item);
            n_sent++;
        end
    end

    // Receiver stall pattern, with one long hold-off early in the run.
    int phase = 0;
    int hold_count = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            phase++;
            if (n_sent == 30 && hold_count == 0 && !hold_off)
            begin
                hold_off = 1'b1;
                hold_count = 400;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                res_stall <= 1'b1;
            end
            else if ((phase / 600) % 3 == 2)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 99) < 35);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        afi_pkg::afi_out_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            n_cols++;
            if (column_q.size() == 0)
            begin
                $error("unexpected column transfer: %p", res);
                errors++;
            end
            else
            begin
                e = column_q.pop_front();
                if (res.column_index !== e.column_index)
                begin
                    $error("column_index expected %0d got %0d", e.column_index,
                           res.column_index);
                    errors++;
                end
                if (res.out_x !== e.out_x)
                begin
                    $error("out_x expected %h got %h", e.out_x, res.out_x);
                    errors++;
                end
                if (res.out_y !== e.out_y)
                begin
                    $error("out_y expected %h got %h", e.out_y, res.out_y);
                    errors++;
                end
                if (res.out_z !== e.out_z)
                begin
                    $error("out_z expected %h got %h", e.out_z, res.out_z);
                    errors++;
                end
                if (res.singular !== e.singular)
                begin
                    $error("singular expected %b got %b", e.singular, res.singular);
                    errors++;
                end
                if (res.saturated !== e.saturated)
                begin
                    $error("saturated expected %b got %b", e.saturated, res.saturated);
                    errors++;
                end
                if (res.last !== e.last)
                begin
                    $error("last expected %b got %b", e.last, res.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done && column_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
        $display("Covered %0d transforms, %0d columns checked.", n_sent, n_cols);
        $display("Singular transforms %0d, clipped columns %0d, long output hold-off %0d.",
                 n_singular, n_sat, hold_off);
        if (errors == 0 && column_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: files.f
rtl/afi_pkg.sv
rtl/afi_det.sv
rtl/afi_div.sv
rtl/afi_xlat.sv
rtl/affine_transform_inverse.sv
tb/sv/tb.sv
